### design/life_automaton_torus_grid_top_assert.svh
// Assertion macros for the toroidal life grid.
`ifndef LIFE_AUTOMATON_TORUS_GRID_TOP_ASSERT_SVH
`define LIFE_AUTOMATON_TORUS_GRID_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LATG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define LATG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/latg_pkg.sv
// Shared types, constants and functions for the toroidal life grid.
`default_nettype none

package latg_pkg;

  localparam int DEF_GRID_COLS = 64;
  localparam int DEF_GRID_ROWS = 32;

  localparam int CMD_W   = 2;
  localparam int COLIN_W = 6;
  localparam int ROWIN_W = 5;
  localparam int CNT_W   = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_STEP,
    ST_ACCESS
  } state_t;

  typedef struct packed {
    logic shift;
    logic wr;
    logic wr_bit;
  } cell_ctl_t;

  localparam logic [CNT_W-1:0] BIRTH_CNT   = 4'd3;
  localparam logic [CNT_W-1:0] SURVIVE_CNT = 4'd2;

  function automatic logic [CNT_W-1:0] count8(input logic [7:0] nb);
    logic [CNT_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, nb[i]};
    end
    return sum;
  endfunction

  // B3/S23
  function automatic logic next_alive(input logic alive, input logic [CNT_W-1:0] cnt);
    return (cnt == BIRTH_CNT) || (alive && (cnt == SURVIVE_CNT));
  endfunction

endpackage

`default_nettype wire

### design/life_automaton_torus_grid_top.sv
// Top level of the toroidal life grid: ring of row cells, head row logic and control.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------------
//  in      | in  | in_valid, in_stall  | command, col, row, alive_in
//  out     | out | out_valid, out_stall| cell_alive, neighbor_count
//
// Rows sit in a ring of cells that rotates by one row a cycle while seeking or stepping; a
// write only touches the head row. Read/write: accept, then seek (the ring rotates until the row
// is at the head, after any out-of-range row or column is wrapped, both at once), then access.
// Step: accept, then one row updated per cycle as the ring rotates once, then a report.
// Reset (rst, synchronous) clears every cell at once. One item in flight; a stalled
// result register holds the block in its access cycle.
`default_nettype none

`include "life_automaton_torus_grid_top_assert.svh"

module life_automaton_torus_grid_top #(
  parameter int GRID_COLS = latg_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = latg_pkg::DEF_GRID_ROWS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [latg_pkg::CMD_W-1:0]    command,
  input  wire logic [latg_pkg::COLIN_W-1:0]  col,
  input  wire logic [latg_pkg::ROWIN_W-1:0]  row,
  input  wire logic                          alive_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               cell_alive,
  output logic      [latg_pkg::CNT_W-1:0]    neighbor_count
);

  localparam int COL_W = $clog2(GRID_COLS);
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int CQ_W  = (COL_W > latg_pkg::COLIN_W) ? COL_W : latg_pkg::COLIN_W;
  localparam int RQ_W  = (ROW_W > latg_pkg::ROWIN_W) ? ROW_W : latg_pkg::ROWIN_W;

  latg_pkg::state_t         state, state_next;
  logic [latg_pkg::CMD_W-1:0] cmd_q;
  logic [CQ_W-1:0]          col_q;
  logic [RQ_W-1:0]          row_q;
  logic                     alive_q;
  logic [ROW_W-1:0]         head_row;
  logic [ROW_W-1:0]         step_cnt;
  logic [GRID_COLS-1:0]     prev_old;
  logic [GRID_COLS-1:0]     first_old;

  logic [GRID_COLS-1:0]     rows [GRID_ROWS];
  logic [GRID_COLS-1:0]     tail_in;
  logic [GRID_COLS-1:0]     upd_above, upd_below, upd_row;

  latg_pkg::cell_ctl_t      head_ctl, ring_ctl;
  logic                     shift, wr, out_free, out_load, step_last;
  logic                     row_ok, col_ok, aligned, is_step, is_write;
  logic [ROW_W-1:0]         row_idx;
  logic [COL_W-1:0]         col_idx, col_l, col_r;
  logic                     res_alive;
  logic [latg_pkg::CNT_W-1:0] res_cnt;

  assign is_step   = (cmd_q == latg_pkg::CMD_STEP);
  assign is_write  = (cmd_q == latg_pkg::CMD_WRITE);
  assign row_ok    = ({1'b0, row_q} < (RQ_W + 1)'(GRID_ROWS));
  assign col_ok    = ({1'b0, col_q} < (CQ_W + 1)'(GRID_COLS));
  assign row_idx   = row_q[ROW_W-1:0];
  assign col_idx   = col_q[COL_W-1:0];
  assign aligned   = row_ok && col_ok && (head_row == row_idx);
  assign step_last = (step_cnt == ROW_W'(GRID_ROWS - 1));
  assign out_free  = !out_valid || !out_stall;
  assign col_l     = (col_idx == '0) ? COL_W'(GRID_COLS - 1) : col_idx - 1'b1;
  assign col_r     = (col_idx == COL_W'(GRID_COLS - 1)) ? '0 : col_idx + 1'b1;

  // row ring
  for (genvar i = 0; i < GRID_ROWS; i++) begin : g_ring
    latg_cell #(
      .GRID_COLS(GRID_COLS)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   ((i == 0) ? head_ctl : ring_ctl),
      .wr_col(col_idx),
      .row_in((i == GRID_ROWS - 1) ? tail_in : rows[(i + 1) % GRID_ROWS]),
      .row_q (rows[i])
    );
  end

  // during a step the rows behind the head are already new; use saved old copies
  assign upd_above = (step_cnt == '0) ? rows[GRID_ROWS-1] : prev_old;
  assign upd_below = step_last ? first_old : rows[1];

  latg_row_update #(
    .GRID_COLS(GRID_COLS)
  ) u_update (
    .above   (upd_above),
    .mid     (rows[0]),
    .below   (upd_below),
    .row_next(upd_row)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      latg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (command == latg_pkg::CMD_STEP) ? latg_pkg::ST_STEP
                                                       : latg_pkg::ST_SEEK;
        end
      end
      latg_pkg::ST_SEEK: begin
        if (aligned) state_next = latg_pkg::ST_ACCESS;
      end
      latg_pkg::ST_STEP: begin
        if (step_last) state_next = latg_pkg::ST_ACCESS;
      end
      latg_pkg::ST_ACCESS: begin
        if (out_free) state_next = latg_pkg::ST_IDLE;
      end
      default: state_next = latg_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall = 1'b1;
    shift    = 1'b0;
    wr       = 1'b0;
    out_load = 1'b0;
    tail_in  = rows[0];
    case (state)
      latg_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      latg_pkg::ST_SEEK: begin
        shift = row_ok && col_ok && (head_row != row_idx);
      end
      latg_pkg::ST_STEP: begin
        shift   = 1'b1;
        tail_in = upd_row;
      end
      latg_pkg::ST_ACCESS: begin
        out_load = out_free;
        wr       = out_free && is_write;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign ring_ctl = '{shift: shift, wr: 1'b0, wr_bit: 1'b0};
  assign head_ctl = '{shift: shift, wr: wr, wr_bit: alive_q};

  // result of the access cycle, zero for a step; the count never includes the cell itself
  always_comb begin
    res_alive = 1'b0;
    res_cnt   = '0;
    if (!is_step) begin
      res_alive = is_write ? alive_q : rows[0][col_idx];
      res_cnt   = latg_pkg::count8({rows[GRID_ROWS-1][col_l], rows[GRID_ROWS-1][col_idx],
                                    rows[GRID_ROWS-1][col_r], rows[0][col_l],
                                    rows[0][col_r], rows[1][col_l], rows[1][col_idx],
                                    rows[1][col_r]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= latg_pkg::ST_IDLE;
      head_row  <= '0;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (shift) begin
        head_row <= (head_row == ROW_W'(GRID_ROWS - 1)) ? '0 : head_row + 1'b1;
      end
      if (state == latg_pkg::ST_STEP) begin
        step_cnt <= step_last ? '0 : step_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == latg_pkg::ST_IDLE && in_valid) begin
      cmd_q   <= command;
      col_q   <= CQ_W'(col);
      row_q   <= RQ_W'(row);
      alive_q <= alive_in;
    end else if (state == latg_pkg::ST_SEEK) begin
      if (!row_ok) row_q <= row_q - RQ_W'(GRID_ROWS);
      if (!col_ok) col_q <= col_q - CQ_W'(GRID_COLS);
    end
    if (state == latg_pkg::ST_STEP) begin
      prev_old <= rows[0];
      if (step_cnt == '0) first_old <= rows[0];
    end
    if (out_load) begin
      cell_alive     <= res_alive;
      neighbor_count <= res_cnt;
    end
  end

  `LATG_ASSERT_IMP(a_access_aligned,
    (state == latg_pkg::ST_ACCESS) && !is_step, aligned,
    "access on a row that is not at the head")
  `LATG_ASSERT_IMP(a_step_cnt_idle,
    state != latg_pkg::ST_STEP, step_cnt == '0,
    "step counter running outside a step")
  `LATG_ASSERT_NXT(a_out_only_access,
    (state != latg_pkg::ST_ACCESS) && !out_valid, !out_valid,
    "result raised outside the access cycle")
  `LATG_ASSERT_NXT(a_access_exit,
    (state == latg_pkg::ST_ACCESS) && out_free, state == latg_pkg::ST_IDLE && out_valid,
    "access cycle did not hand over its result")

endmodule

`default_nettype wire

### design/latg_cell.sv
// One grid row held in the ring; shifts to its neighbour or takes a single-bit write.
`default_nettype none

module latg_cell #(
  parameter int GRID_COLS = latg_pkg::DEF_GRID_COLS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire latg_pkg::cell_ctl_t          ctl,
  input  wire logic [$clog2(GRID_COLS)-1:0] wr_col,
  input  wire logic [GRID_COLS-1:0]         row_in,
  output logic      [GRID_COLS-1:0]         row_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_q <= '0;
    end else if (ctl.shift) begin
      row_q <= row_in;
    end else if (ctl.wr) begin
      row_q[wr_col] <= ctl.wr_bit;
    end
  end

endmodule

`default_nettype wire

### design/latg_row_update.sv
// Next generation of one row from the old rows above, at and below it.
`default_nettype none

module latg_row_update #(
  parameter int GRID_COLS = latg_pkg::DEF_GRID_COLS
) (
  input  wire logic [GRID_COLS-1:0] above,
  input  wire logic [GRID_COLS-1:0] mid,
  input  wire logic [GRID_COLS-1:0] below,
  output logic      [GRID_COLS-1:0] row_next
);

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
    localparam int L = (c + GRID_COLS - 1) % GRID_COLS;
    localparam int R = (c + 1) % GRID_COLS;
    logic [latg_pkg::CNT_W-1:0] cnt;
    assign cnt = latg_pkg::count8({above[L], above[c], above[R], mid[L], mid[R],
                                   below[L], below[c], below[R]});
    assign row_next[c] = latg_pkg::next_alive(mid[c], cnt);
  end

endmodule

`default_nettype wire
